FILE: rtl/trle_pkg.sv
// Package for the tile run-length encoder: request types and constants.
`default_nettype none
package trle_pkg;

  // Longest run before a forced emission; lengths above 255 do not fit a run.
  localparam int MAX_RUN = 255;
  localparam logic [7:0] RUN_CAP = (MAX_RUN > 255) ? 8'd255 : 8'(MAX_RUN);

  // Result queue: one item may close a run and flush another.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [2:0] KIND_EMPTY = 3'd0;

  typedef struct packed {
    logic [2:0]  tile_kind;
    logic [31:0] tile_ref;
    logic        final_tile;
  } tile_t;

  typedef struct packed {
    logic [2:0]  run_kind;
    logic [7:0]  run_length;
    logic [31:0] run_ref;
    logic        ref_present;
    logic        run_last;
  } run_t;

endpackage
`default_nettype wire

FILE: rtl/tile_run_length_encoder_unit.sv
// Top level of the tile run-length encoder.
//
// Tile requests come in on tile/tile_valid/tile_stall, one tile per accepted
// request. Run requests leave on run/run_valid/run_stall. Each tile is
// compared with the stored previous tile (the index is ignored for the empty
// kind) and the run count is advanced. A tile may close the pending run, hit
// the run length cap, or, when final_tile is set, flush the current run, so
// one tile yields zero, one or two runs.
//
// Runs are written straight into a four-entry result queue at the accepting
// edge, so a run is in the queue, with run_valid high, in the cycle after its tile is taken.
// A tile is taken every cycle while the queue has two free entries; a
// stream whose tiles make one run each keeps that rate, and each tile that
// makes two runs needs two pops on the output side.
//
// When the receiver stalls, the queue fills and tile_stall rises once fewer
// than two entries are free; the run at the head holds still.
// Reset (rst, synchronous, active high) empties the queue and returns the
// encoder to the start of a chunk: previous tile empty, run count zero.
// After a final tile the encoder also returns to that start state.
`default_nettype none
module tile_run_length_encoder_unit
  import trle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire tile_t tile,
  input  wire logic  tile_valid,
  output logic       tile_stall,
  output run_t       run,
  output logic       run_valid,
  input  wire logic  run_stall
);

  // encoder state
  logic [2:0]  prev_kind, prev_kind_next;
  logic [31:0] prev_ref, prev_ref_next;
  logic [7:0]  run_count, run_count_next;

  // result queue
  run_t             oq [OQ_DEPTH];
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_CW-1:0] oq_count;

  logic        take;
  logic        pop;
  logic [31:0] ref_eff;
  logic        differ;
  logic [7:0]  cnt_inc;
  logic        emit_a, emit_b;
  run_t        run_a, run_b;
  logic [7:0]  cnt_after;
  logic [1:0]  n_push;

  assign tile_stall = (oq_count > OQ_CW'(OQ_DEPTH - 2));
  assign take       = tile_valid && !tile_stall;
  assign run_valid  = (oq_count != '0);
  assign pop        = run_valid && !run_stall;
  assign run        = oq[rd_ptr];

  always_comb begin
    // empty tiles are stored and compared with index zero
    ref_eff = (tile.tile_kind == KIND_EMPTY) ? 32'd0 : tile.tile_ref;
    differ  = (tile.tile_kind != prev_kind) || (ref_eff != prev_ref);
    cnt_inc = run_count + 8'd1;

    run_a.run_kind    = prev_kind;
    run_a.run_ref     = prev_ref;
    run_a.ref_present = (prev_kind != KIND_EMPTY);
    run_a.run_length  = differ ? run_count : cnt_inc;
    run_a.run_last    = 1'b0;

    if (differ) begin
      // close previous run, unless it is empty
      emit_a    = (run_count != 8'd0);
      cnt_after = 8'd1;
    end else begin
      emit_a    = (cnt_inc >= RUN_CAP);
      cnt_after = emit_a ? 8'd0 : cnt_inc;
    end

    // flush on the final tile; stored tile equals the incoming one here
    emit_b            = tile.final_tile && (cnt_after != 8'd0);
    run_b.run_kind    = tile.tile_kind;
    run_b.run_ref     = ref_eff;
    run_b.ref_present = (tile.tile_kind != KIND_EMPTY);
    run_b.run_length  = cnt_after;
    run_b.run_last    = 1'b1;
    if (tile.final_tile && !emit_b) begin
      run_a.run_last = 1'b1;
    end

    if (tile.final_tile) begin
      prev_kind_next = KIND_EMPTY;
      prev_ref_next  = 32'd0;
      run_count_next = 8'd0;
    end else begin
      prev_kind_next = tile.tile_kind;
      prev_ref_next  = ref_eff;
      run_count_next = cnt_after;
    end

    n_push = take ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kind <= KIND_EMPTY;
      prev_ref  <= 32'd0;
      run_count <= 8'd0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      oq_count  <= '0;
    end else begin
      if (take) begin
        prev_kind <= prev_kind_next;
        prev_ref  <= prev_ref_next;
        run_count <= run_count_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      wr_ptr   <= wr_ptr + OQ_AW'(n_push);
      oq_count <= oq_count + OQ_CW'(n_push) - OQ_CW'(pop);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      if (emit_a) begin
        oq[wr_ptr] <= run_a;
        if (emit_b) begin
          oq[wr_ptr + OQ_AW'(1)] <= run_b;
        end
      end else if (emit_b) begin
        oq[wr_ptr] <= run_b;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/trle_checker.sv
// Port-level checks for the tile run-length encoder, bound to the top level.
`default_nettype none
module trle_checker
  import trle_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire tile_t tile,
  input wire logic  tile_valid,
  input wire logic  tile_stall,
  input wire run_t  run,
  input wire logic  run_valid,
  input wire logic  run_stall
);

  // a stalled run request holds its payload
  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> run_valid && $stable(run))
    else $error("run request changed under stall");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> run.run_length != 8'd0 && run.run_length <= RUN_CAP)
    else $error("run length out of range");

  a_ref_flag: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> run.ref_present == (run.run_kind != KIND_EMPTY))
    else $error("ref_present does not follow kind");

  a_ref_zero: assert property (@(posedge clk) disable iff (rst)
    run_valid && !run.ref_present |-> run.run_ref == 32'd0)
    else $error("empty run carries an index");

  // an accepted final tile on an empty queue shows a run next cycle
  a_flush: assert property (@(posedge clk) disable iff (rst)
    tile_valid && !tile_stall && tile.final_tile && !run_valid |=> run_valid)
    else $error("final tile produced no run");

endmodule

bind tile_run_length_encoder_unit trle_checker u_trle_checker (
  .clk        (clk),
  .rst        (rst),
  .tile       (tile),
  .tile_valid (tile_valid),
  .tile_stall (tile_stall),
  .run        (run),
  .run_valid  (run_valid),
  .run_stall  (run_stall)
);
`default_nettype wire

FILE: verif/trle_run_checker.sv
// Run checker for the tile run-length encoder: predicts runs from accepted tiles and compares.
module trle_run_checker
  import trle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  tile_t tile,
  input  logic  tile_valid,
  input  logic  tile_stall,
  input  run_t  run,
  input  logic  run_valid,
  input  logic  run_stall,
  output int    mismatches,
  output int    runs_waiting,
  output int    runs_checked
);

  logic [2:0]  held_kind;
  logic [31:0] held_ref;
  logic [7:0]  held_count;
  run_t        expected_runs[$];

  function automatic run_t make_run(logic [2:0] kind, logic [31:0] idx, logic [7:0] len);
    run_t r;
    r.run_kind    = kind;
    r.run_length  = len;
    r.ref_present = (kind != KIND_EMPTY);
    r.run_ref     = r.ref_present ? idx : 32'd0;
    r.run_last    = 1'b0;
    return r;
  endfunction

  task automatic clear_run_state();
    held_kind  = KIND_EMPTY;
    held_ref   = '0;
    held_count = '0;
  endtask

  // Compress one tile into the expected run stream.
  task automatic encode_tile(input tile_t t);
    logic [2:0]  kind;
    logic [31:0] idx;
    int          base;
    run_t        tail;
    kind = t.tile_kind;
    idx  = (kind == KIND_EMPTY) ? 32'd0 : t.tile_ref;
    base = expected_runs.size();
    if (kind != held_kind || idx != held_ref) begin
      if (held_count != 0) expected_runs.push_back(make_run(held_kind, held_ref, held_count));
      held_kind  = kind;
      held_ref   = idx;
      held_count = 8'd1;
    end else begin
      held_count = held_count + 8'd1;
      if (held_count >= RUN_CAP) begin
        expected_runs.push_back(make_run(held_kind, held_ref, held_count));
        held_count = '0;
      end
    end
    if (t.final_tile) begin
      if (held_count != 0) expected_runs.push_back(make_run(held_kind, held_ref, held_count));
      // last run produced by this tile carries the end-of-chunk mark
      if (expected_runs.size() > base) begin
        tail = expected_runs.pop_back();
        tail.run_last = 1'b1;
        expected_runs.push_back(tail);
      end
      clear_run_state();
    end
  endtask

  task automatic check_run(input run_t got);
    run_t want;
    if (expected_runs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected run: kind %0d len %0d ref %h present %b last %b",
                 got.run_kind, got.run_length, got.run_ref, got.ref_present, got.run_last);
    end else begin
      want = expected_runs.pop_front();
      runs_checked++;
      if (got.run_kind !== want.run_kind || got.run_length !== want.run_length ||
          got.run_ref !== want.run_ref || got.ref_present !== want.ref_present ||
          got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("run %0d: exp kind %0d len %0d ref %h present %b last %b, got kind %0d len %0d ref %h present %b last %b",
                   runs_checked, want.run_kind, want.run_length, want.run_ref,
                   want.ref_present, want.run_last, got.run_kind, got.run_length,
                   got.run_ref, got.ref_present, got.run_last);
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    runs_waiting = 0;
    runs_checked = 0;
    clear_run_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_run_state();
      expected_runs.delete();
    end else begin
      if (tile_valid && !tile_stall) encode_tile(tile);
      if (run_valid && !run_stall) check_run(run);
    end
    runs_waiting = expected_runs.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the tile run-length encoder: tile stimulus, run stalls and verdict.
module tb_top;
  import trle_pkg::*;

  logic  clk;
  logic  rst;
  tile_t tile;
  logic  tile_valid;
  logic  tile_stall;
  run_t  run;
  logic  run_valid;
  logic  run_stall;

  int mismatches;
  int runs_waiting;
  int runs_checked;

  int tiles_sent;
  int chunks_sent;
  // calm stretches: both sides stop idling so requests go back to back
  bit calm;

  tile_run_length_encoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .tile       (tile),
    .tile_valid (tile_valid),
    .tile_stall (tile_stall),
    .run        (run),
    .run_valid  (run_valid),
    .run_stall  (run_stall)
  );

  // Watches both channels, predicts the runs and counts mismatches.
  trle_run_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .tile         (tile),
    .tile_valid   (tile_valid),
    .tile_stall   (tile_stall),
    .run          (run),
    .run_valid    (run_valid),
    .run_stall    (run_stall),
    .mismatches   (mismatches),
    .runs_waiting (runs_waiting),
    .runs_checked (runs_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #20000000;
    $display("tile_run_length_encoder_unit: mismatch");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Run side: per run, stall a drawn number of cycles, then take one run.
  initial begin
    int n;
    run_stall = 1'b0;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        run_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      run_stall = 1'b0;
      @(posedge clk);
      while (run_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // One tile request. Drives at the falling edge, waits for acceptance at the rising edge.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_tile(input logic [2:0] kind, input logic [31:0] idx, input logic close);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      tile_valid = 1'b0;
      // junk on the bus while idle
      tile.tile_kind  = 3'($urandom);
      tile.tile_ref   = $urandom;
      tile.final_tile = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    tile_valid      = 1'b1;
    tile.tile_kind  = kind;
    tile.tile_ref   = idx;
    tile.final_tile = close;
    @(posedge clk);
    while (tile_stall) @(posedge clk);
    @(negedge clk);
    tiles_sent++;
    if (close) chunks_sent++;
  endtask

  // A run of identical tiles; empty tiles get a different junk index on each tile.
  task automatic send_run(input logic [2:0] kind, input logic [31:0] idx, input int len,
                          input bit close);
    for (int i = 0; i < len; i++)
      send_tile(kind, (kind == KIND_EMPTY) ? $urandom : idx, close && (i == len - 1));
  endtask

  initial begin
    int nruns;
    int sel;
    int len;
    logic [2:0]  kind;
    logic [31:0] idx;

    tiles_sent  = 0;
    chunks_sent = 0;
    calm        = 1'b0;
    rst         = 1'b1;
    tile_valid  = 1'b0;
    tile        = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // --- directed tiles ---
    // lone empty tile on the final: index ignored, one run of length one
    send_tile(KIND_EMPTY, 32'hFFFF_FFFF, 1'b1);
    // same kind, index change splits the run; final closes one and flushes another
    send_tile(3'd7, 32'hFFFF_FFFF, 1'b0);
    send_tile(3'd7, 32'hFFFF_FFFF, 1'b0);
    send_tile(3'd7, 32'h0000_0000, 1'b1);
    // empty tiles with differing indices still form one run
    send_tile(KIND_EMPTY, 32'd5, 1'b0);
    send_tile(KIND_EMPTY, 32'd9, 1'b0);
    send_tile(KIND_EMPTY, 32'd0, 1'b1);
    // every kind once
    for (int k = 0; k < 8; k++)
      send_tile(3'(k), 32'hA5A5_0000 | k, k == 7);
    // index flips back and forth within one kind
    send_tile(3'd3, 32'd1, 1'b0);
    send_tile(3'd3, 32'd2, 1'b0);
    send_tile(3'd3, 32'd2, 1'b0);
    send_tile(3'd3, 32'd1, 1'b1);

    // --- length cap ---
    // cap hit exactly on the final tile: flush finds zero count, cap run is marked last
    send_run(3'd5, $urandom, 255, 1'b1);
    // cap hit, then a differing tile: the zero-length run is not emitted
    send_run(3'd2, $urandom, 255, 1'b0);
    send_tile(3'd6, $urandom, 1'b1);
    // two full caps of empty tiles, then a short tail of the same kind
    send_run(KIND_EMPTY, 32'd0, 510, 1'b0);
    send_run(KIND_EMPTY, 32'd0, 3, 1'b1);
    // one past the cap
    send_run(3'd1, 32'hFFFF_FFFF, 256, 1'b1);

    // --- random chunks, until the total reaches the tile budget ---
    while (tiles_sent < 1700) begin
      if ($urandom_range(0, 5) == 0) calm = ~calm;
      if ($urandom_range(0, 9) == 0) begin
        // noise: unrelated tiles, final flag at random
        for (int i = $urandom_range(1, 12); i > 0; i--)
          send_tile(3'($urandom), $urandom, $urandom_range(0, 7) == 0);
      end else begin
        nruns = $urandom_range(1, 8);
        for (int r = 0; r < nruns; r++) begin
          kind = 3'($urandom);
          // small indices make neighboring runs collide and merge now and then
          idx  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
          sel  = $urandom_range(0, 49);
          if (sel == 0)     len = $urandom_range(250, 260);
          else if (sel < 8) len = $urandom_range(7, 30);
          else              len = $urandom_range(1, 6);
          send_run(kind, idx, len, r == nruns - 1);
        end
      end
    end
    tile_valid = 1'b0;
    calm       = 1'b0;

    // drain: wait for every predicted run, then let the bench idle
    for (int i = 0; i < 5000 && runs_waiting != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("sent %0d tiles in %0d chunks, checked %0d runs (%0d failures)",
             tiles_sent, chunks_sent, runs_checked, mismatches);
    $display("covered all kinds, empty-index masking, length cap and end-of-chunk flushes");
    if (mismatches == 0 && runs_waiting == 0) begin
      $display("tile_run_length_encoder_unit: match");
    end else begin
      $display("tile_run_length_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
